### sv/lpwc_pkg.sv
// Package for the longest pass window center block.
// Holds tap count, word types and the all-pass center positions; no dependencies.
package lpwc_pkg;

    // Number of delay taps examined, bits 0 to TAP_COUNT-1
    localparam int TAP_COUNT = 16;
    // Width of the pass word and of the center mask
    localparam int WORD_W    = 16;

    // Centers marked when every tap passes
    localparam int ALL_LO    = (TAP_COUNT - 1) / 2;
    localparam int ALL_HI    = TAP_COUNT / 2;

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [TAP_COUNT-1:0] tap_t;
    // Taps with a zero guard bit at each end
    typedef logic [TAP_COUNT+1:0] tap_pad_t;

endpackage

### sv/longest_pass_window_center_top.sv
// Longest pass window center: input register, center finder, output register.
// An accepted item is held in the input register, then moves to the output register
// that drives m_tvalid once the output side is free (two register stages).
// Throughput: one item per cycle while m_tready is high; the output register also acts as skid stage.
// Reset (rst_n low, asynchronous) clears both stage valid flags; data is not reset.
// Depends on lpwc_pkg and lpwc_center.
module longest_pass_window_center_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  lpwc_pkg::word_t s_tdata,   // [15:0] tap_pass_word
    output logic            m_tvalid,
    input  logic            m_tready,
    output lpwc_pkg::word_t m_tdata    // [15:0] center_mask
);
    import lpwc_pkg::*;

    logic  in_valid_reg,  in_valid_next;
    word_t in_word_reg;
    logic  out_valid_reg, out_valid_next;
    word_t out_mask_reg;
    word_t mask_comb;
    logic  out_free;
    logic  in_move;

    // Stage handshake
    assign out_free = !out_valid_reg || m_tready;
    assign in_move  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Center finder between the two registers
    lpwc_center u_center (
        .tap_pass_word (in_word_reg),
        .center_mask   (mask_comb)
    );

    // Next valid flags
    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (in_move)
            in_valid_next = 1'b0;
        if (in_move)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_word_reg <= s_tdata;
        if (in_move)
            out_mask_reg <= mask_comb;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_mask_reg;

endmodule

### sv/lpwc_center.sv
// Combinational center finder: marks the centers of all longest runs of ones.
// Depends on lpwc_pkg.
module lpwc_center (
    input  lpwc_pkg::word_t tap_pass_word,
    output lpwc_pkg::word_t center_mask
);
    import lpwc_pkg::*;

    tap_t     taps;
    tap_pad_t taps_pad;
    tap_t     len_mask [1:TAP_COUNT];
    logic     len_seen [1:TAP_COUNT];
    tap_t     best_mask;
    logic     all_pass;

    // Map the input word onto the tap vector; bits beyond it are ignored
    always_comb
    begin
        for (int i = 0; i < TAP_COUNT; i++)
        begin
            if (i < WORD_W)
                taps[i] = tap_pass_word[i];
            else
                taps[i] = 1'b0;
        end
        taps_pad = {1'b0, taps, 1'b0};
        all_pass = &taps;
    end

    // For each length, find every maximal run of exactly that length and mark its
    // center; each (start, length) pair is checked independently
    always_comb
    begin
        logic run;
        for (int len = 1; len <= TAP_COUNT; len++)
        begin
            len_mask[len] = '0;
            len_seen[len] = 1'b0;
            for (int s = 0; s <= TAP_COUNT - len; s++)
            begin
                // Guard bits: taps_pad[s] is tap s-1, taps_pad[s+len+1] is tap s+len
                run = !taps_pad[s] && !taps_pad[s + len + 1];
                for (int k = 0; k < len; k++)
                    run = run && taps[s + k];
                if (run)
                    len_mask[len][s + (len - 1) / 2] = 1'b1;
                len_seen[len] = len_seen[len] || run;
            end
        end
    end

    // Pick the mask of the greatest length present; all-pass marks both middles
    always_comb
    begin
        best_mask = '0;
        for (int len = 1; len <= TAP_COUNT; len++)
        begin
            if (len_seen[len])
                best_mask = len_mask[len];
        end
        if (all_pass)
        begin
            best_mask         = '0;
            best_mask[ALL_LO] = 1'b1;
            best_mask[ALL_HI] = 1'b1;
        end
    end

    // Fit to the output field; centers past its top are dropped
    always_comb
    begin
        for (int i = 0; i < WORD_W; i++)
        begin
            if (i < TAP_COUNT)
                center_mask[i] = best_mask[i];
            else
                center_mask[i] = 1'b0;
        end
    end

endmodule

### sv/lpwc_checker.sv
// Port-level checker for the longest pass window center block, with its bind.
// Depends on lpwc_pkg and longest_pass_window_center_top.
module lpwc_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic            s_tready,
    input  lpwc_pkg::word_t s_tdata,
    input  logic            m_tvalid,
    input  logic            m_tready,
    input  lpwc_pkg::word_t m_tdata
);
    import lpwc_pkg::*;

    logic       in_acc;
    logic       out_acc;
    logic [1:0] occ_reg, occ_next;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // Items inside the block: accepted but not yet delivered
    always_comb
    begin
        occ_next = occ_reg;
        if (in_acc && !out_acc)
            occ_next = occ_reg + 2'd1;
        else if (out_acc && !in_acc)
            occ_next = occ_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= 2'd0;
        else
            occ_reg <= occ_next;
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Never more than two items held
    a_occ_max: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg != 2'd3)
        else $error("more than two items held");

    // No result without an accepted item
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> occ_reg != 2'd0)
        else $error("result shown with no item inside");

    // Both stages full and output stalled: input must stall
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == 2'd2 && !m_tready |-> !s_tready)
        else $error("item accepted while both stages full");

endmodule

bind longest_pass_window_center_top lpwc_checker u_lpwc_checker (.*);

### tb/testbench.sv
// Self-checking testbench for longest_pass_window_center_top: stream driver and monitor,
// with a built-in predictor for the centers of the longest passing tap windows.
// Depends on lpwc_pkg and the block's RTL; reads no files.
`timescale 1ns / 100ps

module testbench;
    import lpwc_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RESET_LEN   = 9;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_LEN    = 150;
    localparam int DRAIN_WAIT  = 8;
    localparam int MAX_REPORTS = 10;

    logic  clk      = 1'b0;
    logic  rst_n    = 1'b0;
    logic  s_tvalid = 1'b0;
    logic  s_tready;
    word_t s_tdata  = '0;
    logic  m_tvalid;
    logic  m_tready = 1'b0;
    word_t m_tdata;

    // Stimulus and scoreboard storage
    word_t tap_words_to_send[$];
    word_t center_masks_due[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    int hold_left     = 0;
    int words_accepted = 0;
    int masks_checked  = 0;
    int mismatches     = 0;
    int unexpected     = 0;
    int cycle_count    = 0;

    longest_pass_window_center_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF clk = ~clk;

    // Center of every longest run of set taps; even runs take the lower middle bit, all-pass marks both
    function automatic word_t longest_run_centers(word_t tap_word);
        word_t centers;
        int    best;
        int    run_start;
        int    run_len;
        int    ctr;
        logic  tap_bit;
        logic  all_pass;
        centers   = '0;
        best      = 0;
        run_start = 0;
        run_len   = 0;
        all_pass  = 1'b1;
        for (int i = 0; i < TAP_COUNT; i++)
        begin
            if (i >= WORD_W || !tap_word[i])
                all_pass = 1'b0;
        end
        if (all_pass)
        begin
            if ((TAP_COUNT - 1) / 2 < WORD_W)
                centers[(TAP_COUNT - 1) / 2] = 1'b1;
            if (TAP_COUNT / 2 < WORD_W)
                centers[TAP_COUNT / 2] = 1'b1;
            return centers;
        end
        // One step past the top tap closes a run that reaches it
        for (int i = 0; i <= TAP_COUNT; i++)
        begin
            tap_bit = (i < TAP_COUNT && i < WORD_W) ? tap_word[i] : 1'b0;
            if (tap_bit)
            begin
                if (run_len == 0)
                    run_start = i;
                run_len++;
            end
            else if (run_len != 0)
            begin
                ctr = run_start + (run_len - 1) / 2;
                if (run_len > best)
                begin
                    best    = run_len;
                    centers = '0;
                end
                if (run_len == best && ctr < WORD_W)
                    centers[ctr] = 1'b1;
                run_len = 0;
            end
        end
        return centers;
    endfunction

    // Random pass words: mostly window-shaped patterns, some noise
    function automatic word_t random_tap_word();
        int    kind;
        int    n_runs;
        int    pos;
        int    len;
        int    gap;
        word_t w;
        kind = $urandom_range(9);
        w    = '0;
        case (kind)
            0, 1:
                w = word_t'($urandom);
            2, 3, 4:
            begin
                n_runs = $urandom_range(1, 3);
                for (int r = 0; r < n_runs; r++)
                begin
                    pos = $urandom_range(WORD_W - 1);
                    len = $urandom_range(1, 10);
                    w  |= word_t'(((32'd1 << len) - 1) << pos);
                end
            end
            5:
            begin
                // two windows of equal length
                len = $urandom_range(1, 6);
                pos = $urandom_range(0, 3);
                gap = $urandom_range(1, 3);
                w   = word_t'(((32'd1 << len) - 1) << pos);
                w  |= word_t'(((32'd1 << len) - 1) << (pos + len + gap));
            end
            6:
                w = word_t'($urandom | $urandom);
            7:
                w = word_t'($urandom & $urandom & $urandom);
            8:
            begin
                // all or nearly all pass, up to two failing taps
                w = '1;
                n_runs = $urandom_range(0, 2);
                for (int r = 0; r < n_runs; r++)
                    w[$urandom_range(WORD_W - 1)] = 1'b0;
            end
            default:
                w = $urandom_range(1) ? word_t'('1) : word_t'('0);
        endcase
        return w;
    endfunction

    // Sender: holds an offered item until taken, then maybe pauses
    always @(posedge clk or negedge rst_n)
    begin : sender
        logic  offer;
        word_t next_word;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            offer     = s_tvalid;
            next_word = s_tdata;
            if (s_tvalid && s_tready)
            begin
                center_masks_due.push_back(longest_run_centers(s_tdata));
                words_accepted++;
                offer = 1'b0;
            end
            if (!offer && tap_words_to_send.size() != 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                offer     = 1'b1;
                next_word = tap_words_to_send.pop_front();
            end
            s_tvalid <= offer;
            s_tdata  <= next_word;
        end
    end

    // Receiver: random stalls plus long hold-offs on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (holds_done < hold_requests)
        begin
            holds_done++;
            hold_left = HOLD_LEN;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: compare each delivered mask with the oldest prediction
    always @(posedge clk)
    begin : mask_monitor
        word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (center_masks_due.size() == 0)
            begin
                unexpected++;
                if (mismatches + unexpected <= MAX_REPORTS)
                    $display("%0t: center_mask 0x%04h with no word pending", $realtime, m_tdata);
            end
            else
            begin
                want = center_masks_due.pop_front();
                masks_checked++;
                if (m_tdata !== want)
                begin
                    mismatches++;
                    if (mismatches + unexpected <= MAX_REPORTS)
                        $display("%0t: center_mask expected 0x%04h, got 0x%04h",
                                 $realtime, want, m_tdata);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d masks outstanding",
                     cycle_count, center_masks_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (tap_words_to_send.size() != 0 || s_tvalid || center_masks_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic queue_random_words(int count);
        for (int k = 0; k < count; k++)
            tap_words_to_send.push_back(random_tap_word());
    endtask

    initial
    begin
        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Phase 1: busy sender, sparse receiver; directed words first
        send_idle_pct = 14;
        recv_idle_pct = 88;
        tap_words_to_send.push_back(16'h0000);  // nothing passes
        tap_words_to_send.push_back(16'hFFFF);  // everything passes
        tap_words_to_send.push_back(16'h0001);  // lowest tap alone
        tap_words_to_send.push_back(16'h8000);  // highest tap alone
        tap_words_to_send.push_back(16'h5555);  // single-tap runs everywhere
        tap_words_to_send.push_back(16'hAAAA);
        tap_words_to_send.push_back(16'h7FFF);  // long run at the bottom
        tap_words_to_send.push_back(16'hFFFE);  // long run at the top
        tap_words_to_send.push_back(16'h3FFF);
        tap_words_to_send.push_back(16'hEFFF);
        tap_words_to_send.push_back(16'h0F0F);  // tie, even length
        tap_words_to_send.push_back(16'h0E0E);  // tie, odd length
        tap_words_to_send.push_back(16'h8001);  // tie at both ends
        tap_words_to_send.push_back(16'hC003);
        tap_words_to_send.push_back(16'h00F0);
        tap_words_to_send.push_back(16'h0070);
        tap_words_to_send.push_back(16'h0180);
        tap_words_to_send.push_back(16'h7FFE);
        tap_words_to_send.push_back(16'h1248);
        tap_words_to_send.push_back(16'hF00F);
        tap_words_to_send.push_back(16'hFF00);
        tap_words_to_send.push_back(16'h00FF);
        queue_random_words(160);
        wait_drained();

        // Phase 2: sparse sender, busy receiver
        send_idle_pct = 88;
        recv_idle_pct = 14;
        queue_random_words(180);
        wait_drained();

        // Phase 3: full rate both ways, with one long output hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_words(190);
        hold_requests++;
        wait_drained();

        repeat (DRAIN_WAIT) @(negedge clk);
        $display("Checked %0d center masks from %0d pass words over three flow-control phases,",
                 masks_checked, words_accepted);
        $display("including a %0d-cycle output hold-off at full input rate.", HOLD_LEN);
        if (mismatches == 0 && unexpected == 0 && center_masks_due.size() == 0)
            $display("RESULT: OK");
        else
        begin
            $display("%0d mismatches, %0d unexpected, %0d missing",
                     mismatches, unexpected, center_masks_due.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
